>>> hw/rtl/hap_pkg.sv
// ----------------------------------------------------------------------------
// hap_pkg: shared types and constants of the hash to address packer
// Transfer payloads, the queue entry between front and back, and constants.
// ----------------------------------------------------------------------------
package hap_pkg;

   localparam logic [7:0] ADDR_PREFIX = 8'h02;
   localparam int         KEPT_BYTES  = 14;
   localparam logic [6:0] KEPT_BITS   = 7'd112;
   localparam logic [3:0] BYTE_BITS   = 4'd8;

   typedef struct packed {
      logic [7:0] hash_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [7:0]  ones_found;
      logic        new_record;
   } rsp_type;

   // Queue entry: the byte, its end flag and its count of leading one bits.
   typedef struct packed {
      logic [7:0] hash_byte;
      logic       last_byte;
      logic [3:0] lead_ones;
   } item_type;

endpackage

>>> hw/rtl/hap_front.sv
// ----------------------------------------------------------------------------
// hap_front: input side of the hash to address packer
// Accepts hash bytes, counts their leading one bits and queues them.
// ----------------------------------------------------------------------------
module hap_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hap_pkg::req_type  req_data,
   output logic              q_valid,
   output hap_pkg::item_type q_item,
   input  logic              q_pop
);
   import hap_pkg::*;

   function automatic logic [3:0] lead_ones(input logic [7:0] b);
      logic [3:0] n;
      logic       run;
      n   = 4'd0;
      run = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (run && b[i]) begin
            n = n + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   new_item;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.hash_byte = req_data.hash_byte;
      new_item.last_byte = req_data.last_byte;
      new_item.lead_ones = lead_ones(req_data.hash_byte);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != 2'd0)
      else $error("queue popped while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_ptr_balance: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
`endif

endmodule

>>> hw/rtl/hap_back.sv
// ----------------------------------------------------------------------------
// hap_back: packing side of the hash to address packer
// Packs one queued byte per cycle into the address; last bytes wait for room.
// ----------------------------------------------------------------------------
module hap_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  hap_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hap_pkg::rsp_type  rsp_data
);
   import hap_pkg::*;

   logic [7:0] ones_ff, ones_in;
   logic       prefix_ff, prefix_in;
   logic [6:0] pbc_ff, pbc_in;
   logic [7:0] partial_ff, partial_in;
   logic [7:0] max_ff;
   logic [7:0] bytes_ff [KEPT_BYTES];
   logic [7:0] bytes_in [KEPT_BYTES];
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic        slot_free;
   logic [3:0]  n_bits, take, total, spill;
   logic [6:0]  room;
   logic [15:0] masked, bits, comb;
   logic        wr_en;
   logic [7:0]  byte_out;
   logic [3:0]  fill;
   logic [7:0]  ob [KEPT_BYTES];

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign q_pop     = q_valid && (!q_item.last_byte || slot_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      // Bits after the prefix and the zero ending it; all once it is done.
      if (prefix_ff) begin
         n_bits = BYTE_BITS;
      end else if (q_item.lead_ones == BYTE_BITS) begin
         n_bits = 4'd0;
      end else begin
         n_bits = 4'd7 - q_item.lead_ones;
      end
      prefix_in = prefix_ff || (q_item.lead_ones != BYTE_BITS);
      ones_in   = prefix_ff ? ones_ff : ones_ff + {4'd0, q_item.lead_ones};

      room   = KEPT_BITS - pbc_ff;
      take   = ({3'd0, n_bits} > room) ? room[3:0] : n_bits;
      masked = {8'd0, q_item.hash_byte} & ((16'd1 << n_bits) - 16'd1);
      bits   = masked >> (n_bits - take);
      comb   = ({8'd0, partial_ff} << take) | bits;
      total  = {1'b0, pbc_ff[2:0]} + take;
      pbc_in = pbc_ff + {3'd0, take};

      wr_en    = (total >= BYTE_BITS);
      spill    = total - BYTE_BITS;
      byte_out = 8'(comb >> spill);
      if (wr_en) begin
         partial_in = 8'(comb & ((16'd1 << spill) - 16'd1));
      end else begin
         partial_in = comb[7:0];
      end

      for (int i = 0; i < KEPT_BYTES; i++) begin
         bytes_in[i] = bytes_ff[i];
      end
      if (wr_en) begin
         bytes_in[pbc_ff[6:3]] = byte_out;
      end

      // Only completed bytes count; the rest of the address reads as zero.
      fill = pbc_in[6:3];
      for (int i = 0; i < KEPT_BYTES; i++) begin
         ob[i] = (4'(i) < fill) ? bytes_in[i] : 8'd0;
      end

      rsp_data_in.addr_high  = {ADDR_PREFIX, ones_in, ob[0], ob[1], ob[2], ob[3],
                                ob[4], ob[5]};
      rsp_data_in.addr_low   = {ob[6], ob[7], ob[8], ob[9], ob[10], ob[11],
                                ob[12], ob[13]};
      rsp_data_in.ones_found = ones_in;
      rsp_data_in.new_record = (ones_in > max_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_ff      <= 8'd0;
         prefix_ff    <= 1'b0;
         pbc_ff       <= 7'd0;
         partial_ff   <= 8'd0;
         max_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            if (q_item.last_byte) begin
               ones_ff    <= 8'd0;
               prefix_ff  <= 1'b0;
               pbc_ff     <= 7'd0;
               partial_ff <= 8'd0;
               if (rsp_data_in.new_record) begin
                  max_ff <= ones_in;
               end
            end else begin
               ones_ff    <= ones_in;
               prefix_ff  <= prefix_in;
               pbc_ff     <= pbc_in;
               partial_ff <= partial_in;
            end
         end
         if (slot_free) begin
            rsp_valid_ff <= q_pop && q_item.last_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && wr_en) begin
         bytes_ff[pbc_ff[6:3]] <= byte_out;
      end
      if (q_pop && q_item.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pbc_range: assert property (@(posedge clock) disable iff (reset)
      pbc_ff <= KEPT_BITS)
      else $error("packed bit count above limit");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_item.last_byte) |=> (pbc_ff == 7'd0 && !prefix_ff && ones_ff == 8'd0))
      else $error("hash state not cleared after final byte");
   a_record_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.new_record) |-> rsp_data_ff.ones_found != 8'd0)
      else $error("new record with zero count");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("pending result dropped");
`endif

endmodule

>>> hw/rtl/hash_to_ipv6_address_packer.sv
// ----------------------------------------------------------------------------
// hash_to_ipv6_address_packer: leading-ones hash to 128-bit address packer
// Counts the leading one bits of a byte-serial hash and packs the rest.
// ----------------------------------------------------------------------------
// Hash bytes arrive one per transfer, first byte first, and the block takes one
// byte every cycle for as long as the addresses it produces are taken. The front
// stage counts each byte's leading ones and places it in a two-entry queue; the
// back stage consumes one queued byte per cycle, handling all eight bits of that
// byte in that cycle. The byte flagged last_byte produces one address transfer,
// which passes through the queue and then into the result register, unless it
// has to wait. A final byte waits at the head of the queue while the previous
// address has not yet been taken; the bytes behind it then fill the queue, and
// the input stalls once both entries are in use.
module hash_to_ipv6_address_packer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hap_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hap_pkg::rsp_type rsp_data
);
   import hap_pkg::*;

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   hap_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   hap_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
